// ----- rtl/core/tirp_pkg.sv -----
// Shared types and constants of the tiled icon raster palette reader.
`default_nettype none
package tirp_pkg;

  localparam logic [1:0] KIND_BITMAP_WRITE  = 2'd0;
  localparam logic [1:0] KIND_PALETTE_WRITE = 2'd1;
  localparam logic [1:0] KIND_ROW_READ      = 2'd2;

  localparam int TILE_BYTES   = 32;
  localparam int TILE_SIDE    = 8;
  localparam int PAL_DEPTH    = 16;
  localparam int PAL_W        = 15;
  localparam int RESULT_LIMIT = 32;
  localparam int ADDR_SPAN    = 512;

  // Tag that follows a pixel read through the memory pipeline.
  typedef struct packed {
    logic [4:0] column;
    logic       last_pixel;
  } pix_tag_t;

endpackage
`default_nettype wire

// ----- rtl/core/tirp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module tirp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tirp_addr_gen.sv -----
// Row sequencer: walks the pixels of one raster row and forms tiled byte addresses.
`default_nettype none
module tirp_addr_gen
  import tirp_pkg::*;
#(
  parameter int TILES_ACROSS = 4,
  parameter int TILES_DOWN   = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [4:0]          start_row,
  input  wire logic                adv,
  output      logic                busy,
  output      logic                rd_en,
  output      logic [$clog2((TILES_ACROSS * TILES_DOWN * TILE_BYTES < ADDR_SPAN) ?
                     TILES_ACROSS * TILES_DOWN * TILE_BYTES : ADDR_SPAN)-1:0] rd_addr,
  output      pix_tag_t            rd_tag
);

  localparam int STORE_BYTES = TILES_ACROSS * TILES_DOWN * TILE_BYTES;
  localparam int BM_DEPTH    = (STORE_BYTES < ADDR_SPAN) ? STORE_BYTES : ADDR_SPAN;
  localparam int BM_AW       = $clog2(BM_DEPTH);
  localparam int IDX_W       = $clog2(STORE_BYTES);
  localparam int ICON_WIDTH  = TILES_ACROSS * TILE_SIDE;
  localparam int COUNT       = (ICON_WIDTH < RESULT_LIMIT) ? ICON_WIDTH : RESULT_LIMIT;
  localparam logic [4:0]       X_LAST = 5'(COUNT - 1);
  localparam logic [IDX_W-1:0] TA_C   = IDX_W'(TILES_ACROSS);

  logic             busy_r, busy_nxt;
  logic [4:0]       row_r, row_nxt;
  logic [4:0]       x_r, x_nxt;
  logic [IDX_W-1:0] tile;
  logic [IDX_W-1:0] byte_idx;

  always_comb begin
    tile     = IDX_W'(row_r[4:3]) * TA_C + IDX_W'(x_r[4:3]);
    byte_idx = (tile << 5) + IDX_W'({row_r[2:0], 2'b00}) + IDX_W'(x_r[2:1]);
  end

  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    x_nxt    = x_r;
    if (start) begin
      busy_nxt = 1'b1;
      row_nxt  = start_row;
      x_nxt    = '0;
    end else if (busy_r && adv) begin
      x_nxt = x_r + 5'd1;
      if (x_r == X_LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    row_r <= row_nxt;
    x_r   <= x_nxt;
  end

  assign busy              = busy_r;
  assign rd_en             = busy_r && adv;
  assign rd_addr           = BM_AW'(byte_idx);
  assign rd_tag.column     = x_r;
  assign rd_tag.last_pixel = (x_r == X_LAST);

endmodule
`default_nettype wire

// ----- rtl/core/tiled_icon_raster_palette_reader.sv -----
// Tiled icon raster palette reader: top level with bitmap and palette memories.
//
// Input channel in_*: one item per write or row read. in_tuser carries the kind
// (bitmap byte write, palette entry write, raster row read); in_tdata carries
// byte_address, write_value and row_number. Writes give no result. A row read
// of a row inside the icon gives one output item per pixel, left to right,
// with out_tlast on the final pixel of the row.
// Output channel out_*: red, green, blue, color_index and column in out_tdata.
// Each pixel passes the bitmap read and then the palette read; the pipeline
// gives one pixel per cycle while the receiver does not stall.
// The input is held while a row is walked; the next item is taken
// once the last bitmap byte of the row has been handed to the palette read.
// When the receiver stalls, the whole pipeline holds: the memories keep their
// read registers and no pixel is lost or repeated.
// Reset clears the sequencer and the pipeline valid flags; the bitmap and the
// palette are not cleared and must be written before they are read.
`default_nettype none
module tiled_icon_raster_palette_reader
  import tirp_pkg::*;
#(
  parameter int TILES_ACROSS = 4,
  parameter int TILES_DOWN   = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,   // byte_address[8:0], write_value[24:9], row_number[29:25]
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // red[7:0], green[15:8], blue[23:16],
                                       // color_index[27:24], column[32:28]
  output      logic        out_tlast
);

  localparam int STORE_BYTES = TILES_ACROSS * TILES_DOWN * TILE_BYTES;
  localparam int BM_DEPTH    = (STORE_BYTES < ADDR_SPAN) ? STORE_BYTES : ADDR_SPAN;
  localparam int BM_AW       = $clog2(BM_DEPTH);
  localparam int PAL_AW      = $clog2(PAL_DEPTH);
  localparam int ICON_HEIGHT = TILES_DOWN * TILE_SIDE;
  localparam int ICON_WIDTH  = TILES_ACROSS * TILE_SIDE;
  localparam int COUNT       = (ICON_WIDTH < RESULT_LIMIT) ? ICON_WIDTH : RESULT_LIMIT;

  logic [8:0]       in_addr;
  logic [15:0]      in_value;
  logic [4:0]       in_row;
  logic             in_acc;
  logic             bm_we, pal_we, row_start;
  logic             adv;
  logic             busy;
  logic             bm_re;
  logic [BM_AW-1:0] bm_raddr;
  logic [7:0]       bm_rdata;
  pix_tag_t         rd_tag;
  logic [3:0]       pal_idx;
  logic [PAL_W-1:0] pal_rdata;

  logic             v1_r, v1_nxt;
  pix_tag_t         tag1_r;
  logic             v2_r, v2_nxt;
  pix_tag_t         tag2_r;
  logic [3:0]       idx2_r;

  assign in_addr  = in_tdata[8:0];
  assign in_value = in_tdata[24:9];
  assign in_row   = in_tdata[29:25];

  // Items are taken only when no row is being walked and no bitmap byte waits
  // for its palette lookup, so writes never race a read of the same store.
  assign in_tready = !busy && !v1_r;
  assign in_acc    = in_tvalid && in_tready;
  assign adv       = !v2_r || out_tready;

  assign bm_we     = in_acc && (in_tuser == KIND_BITMAP_WRITE) &&
                     ({1'b0, in_addr} < 10'(BM_DEPTH));
  assign pal_we    = in_acc && (in_tuser == KIND_PALETTE_WRITE) &&
                     (in_addr < 9'(PAL_DEPTH));
  assign row_start = in_acc && (in_tuser == KIND_ROW_READ) &&
                     ({3'b000, in_row} < 8'(ICON_HEIGHT));

  tirp_addr_gen #(
    .TILES_ACROSS(TILES_ACROSS),
    .TILES_DOWN  (TILES_DOWN)
  ) u_addr_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (row_start),
    .start_row(in_row),
    .adv      (adv),
    .busy     (busy),
    .rd_en    (bm_re),
    .rd_addr  (bm_raddr),
    .rd_tag   (rd_tag)
  );

  tirp_ram #(
    .WIDTH(8),
    .DEPTH(BM_DEPTH)
  ) u_bitmap_ram (
    .clk  (clk),
    .we   (bm_we),
    .waddr(in_addr[BM_AW-1:0]),
    .wdata(in_value[7:0]),
    .re   (bm_re),
    .raddr(bm_raddr),
    .rdata(bm_rdata)
  );

  // The low nibble is the left pixel of each byte.
  assign pal_idx = tag1_r.column[0] ? bm_rdata[7:4] : bm_rdata[3:0];

  tirp_ram #(
    .WIDTH(PAL_W),
    .DEPTH(PAL_DEPTH)
  ) u_palette_ram (
    .clk  (clk),
    .we   (pal_we),
    .waddr(in_addr[PAL_AW-1:0]),
    .wdata(in_value[PAL_W-1:0]),
    .re   (adv),
    .raddr(pal_idx[PAL_AW-1:0]),
    .rdata(pal_rdata)
  );

  always_comb begin
    v1_nxt = v1_r;
    v2_nxt = v2_r;
    if (adv) begin
      v1_nxt = bm_re;
      v2_nxt = v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
    if (adv) begin
      tag1_r <= rd_tag;
      tag2_r <= tag1_r;
      idx2_r <= pal_idx;
    end
  end

  // Each channel times 8 is the 5-bit field shifted up by three.
  assign out_tvalid = v2_r;
  assign out_tlast  = tag2_r.last_pixel;
  assign out_tdata  = {7'b0000000, tag2_r.column, idx2_r,
                       pal_rdata[14:10], 3'b000,
                       pal_rdata[9:5], 3'b000,
                       pal_rdata[4:0], 3'b000};

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready)
    else $error("input accepted while a row is being walked");

  a_palette_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    pal_we |-> !v1_r)
    else $error("palette written while a lookup is pending");

  a_row_starts: assert property (@(posedge clk) disable iff (!rst_n)
    row_start |=> busy)
    else $error("accepted row read did not start the sequencer");

  a_last_column: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[32:28] == 5'(COUNT - 1)))
    else $error("final pixel of a row carries a wrong column");

endmodule
`default_nettype wire

// ----- sim/tirp_checker.sv -----
// Checker for the tiled icon raster palette reader: tracks stores, predicts pixels, compares.
`timescale 1ns / 100ps
module tirp_checker
  import tirp_pkg::*;
#(
  parameter int TILES_ACROSS = 4,
  parameter int TILES_DOWN   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // byte_address[8:0], write_value[24:9], row_number[29:25]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // red[7:0], green[15:8], blue[23:16],
                                  // color_index[27:24], column[32:28]
  input  logic        out_tlast,
  output int          fail_count,
  output int          pixels_pending,
  output int          pixels_checked
);

  localparam int STORE_BYTES = TILES_ACROSS * TILES_DOWN * TILE_BYTES;
  localparam int ICON_WIDTH  = TILES_ACROSS * TILE_SIDE;
  localparam int ICON_HEIGHT = TILES_DOWN * TILE_SIDE;
  localparam int ROW_PIXELS  = ICON_WIDTH < RESULT_LIMIT ? ICON_WIDTH : RESULT_LIMIT;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] color_index;
    logic [4:0] column;
    logic       last_pixel;
  } pixel_t;

  logic [7:0]       bitmap_copy  [STORE_BYTES];
  logic [PAL_W-1:0] palette_copy [PAL_DEPTH];
  logic [4:0]       column_count;
  pixel_t           pixel_queue  [$];

  // Expands one raster row into the pixels the block should emit.
  task automatic predict_row(input logic [4:0] row);
    int         tile;
    int         byte_index;
    logic [7:0] pair;
    logic [3:0] ci;
    logic [PAL_W-1:0] word;
    pixel_t     px;
    column_count = '0;
    for (int x = 0; x < ROW_PIXELS; x++) begin
      tile       = (row >> 3) * TILES_ACROSS + (x >> 3);
      byte_index = tile * TILE_BYTES + (row & 7) * 4 + ((x & 7) >> 1);
      pair       = byte_index < STORE_BYTES ? bitmap_copy[byte_index] : 8'h00;
      // The low nibble is the left pixel of the pair.
      ci         = x[0] ? pair[7:4] : pair[3:0];
      word       = palette_copy[ci];
      px.red         = {word[4:0], 3'b000};
      px.green       = {word[9:5], 3'b000};
      px.blue        = {word[14:10], 3'b000};
      px.color_index = ci;
      px.column      = column_count;
      px.last_pixel  = (x == ROW_PIXELS - 1);
      pixel_queue.push_back(px);
      column_count = column_count + 5'd1;
    end
  endtask

  task automatic take_item(input logic [1:0] kind, input logic [31:0] data);
    logic [8:0]  addr;
    logic [15:0] value;
    logic [4:0]  row;
    addr  = data[8:0];
    value = data[24:9];
    row   = data[29:25];
    case (kind)
      KIND_BITMAP_WRITE: begin
        if (addr < STORE_BYTES) bitmap_copy[addr] = value[7:0];
      end
      KIND_PALETTE_WRITE: begin
        if (addr < PAL_DEPTH) palette_copy[addr[3:0]] = value[PAL_W-1:0];
      end
      KIND_ROW_READ: begin
        if (row < ICON_HEIGHT) predict_row(row);
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (pixel_queue.size() == 0) begin
      $error("pixel with no pending row read: column %0d", out_tdata[32:28]);
      fail_count++;
    end else begin
      want = pixel_queue.pop_front();
      pixels_checked++;
      compare_field("red",         want.red,         out_tdata[7:0]);
      compare_field("green",       want.green,       out_tdata[15:8]);
      compare_field("blue",        want.blue,        out_tdata[23:16]);
      compare_field("color_index", want.color_index, out_tdata[27:24]);
      compare_field("column",      want.column,      out_tdata[32:28]);
      compare_field("last_pixel",  want.last_pixel,  out_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pixel_queue.delete();
      column_count = '0;
    end else begin
      // A pixel leaving at this edge can never belong to a read taken at the same edge.
      if (out_tvalid && out_tready) check_pixel();
      if (in_tvalid && in_tready) take_item(in_tuser, in_tdata);
    end
    pixels_pending = pixel_queue.size();
  end

endmodule

// ----- sim/tb_tiled_icon_raster_palette_reader.sv -----
// Top-level testbench for the tiled icon raster palette reader: stimulus, pacing and verdict.
`timescale 1ns / 100ps
module tb_tiled_icon_raster_palette_reader;
  import tirp_pkg::*;

  localparam int TILES_ACROSS = 4;
  localparam int TILES_DOWN   = 4;
  localparam int ICON_HEIGHT  = TILES_DOWN * TILE_SIDE;
  localparam int ITEM_TARGET  = 330;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // byte_address[8:0], write_value[24:9], row_number[29:25]
  logic [1:0]  in_tuser;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // red[7:0], green[15:8], blue[23:16],
                           // color_index[27:24], column[32:28]
  logic        out_tlast;

  int fail_count;
  int pixels_pending;
  int pixels_checked;

  // What has been written so far, so that no row read touches an unwritten entry.
  logic [7:0] shadow_bitmap [ADDR_SPAN];
  bit         byte_set      [ADDR_SPAN];
  bit         color_set     [PAL_DEPTH];
  int         items_sent;
  int         rows_read;
  bit         src_rush;
  bit         sink_rush;

  tiled_icon_raster_palette_reader #(
    .TILES_ACROSS(TILES_ACROSS),
    .TILES_DOWN  (TILES_DOWN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  tirp_checker #(
    .TILES_ACROSS(TILES_ACROSS),
    .TILES_DOWN  (TILES_DOWN)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pixels_pending(pixels_pending),
    .pixels_checked(pixels_checked)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [8:0] row_byte_addr(input int r, input int c);
    return 9'(((r >> 3) * TILES_ACROSS + (c >> 2)) * TILE_BYTES + (r & 7) * 4 + (c & 3));
  endfunction

  function automatic bit row_ready(input int r);
    logic [8:0] a;
    for (int c = 0; c < TILES_ACROSS * 4; c++) begin
      a = row_byte_addr(r, c);
      if (!byte_set[a]) return 1'b0;
      if (!color_set[shadow_bitmap[a][3:0]] || !color_set[shadow_bitmap[a][7:4]]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [15:0] rand_color();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Presents one item after a random gap and returns at the edge that accepts it.
  task automatic send_item(input logic [1:0] kind, input logic [8:0] addr,
                           input logic [15:0] value, input logic [4:0] row);
    int gap;
    if ($urandom_range(0, 24) == 0) src_rush = !src_rush;
    gap = src_rush ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, row, value, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (kind)
      KIND_BITMAP_WRITE: begin
        shadow_bitmap[addr] = value[7:0];
        byte_set[addr]      = 1'b1;
        items_sent++;
      end
      KIND_PALETTE_WRITE: begin
        if (addr < PAL_DEPTH) begin
          color_set[addr[3:0]] = 1'b1;
          items_sent++;
        end
      end
      KIND_ROW_READ: begin
        items_sent++;
        rows_read++;
      end
      default: ;
    endcase
  endtask

  // Writes every byte of one raster row, any palette entries it needs, then reads it.
  task automatic fill_row(input logic [4:0] r);
    logic [8:0] a;
    for (int c = 0; c < TILES_ACROSS * 4; c++)
      send_item(KIND_BITMAP_WRITE, row_byte_addr(r, c), 16'($urandom_range(0, 65535)),
                5'($urandom_range(0, 31)));
    for (int c = 0; c < TILES_ACROSS * 4; c++) begin
      a = row_byte_addr(r, c);
      if (!color_set[shadow_bitmap[a][3:0]])
        send_item(KIND_PALETTE_WRITE, 9'(shadow_bitmap[a][3:0]), rand_color(),
                  5'($urandom_range(0, 31)));
      if (!color_set[shadow_bitmap[a][7:4]])
        send_item(KIND_PALETTE_WRITE, 9'(shadow_bitmap[a][7:4]), rand_color(),
                  5'($urandom_range(0, 31)));
    end
    send_item(KIND_ROW_READ, 9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)), r);
  endtask

  // Receiver: draws a stall for every pixel, with stretches of no stalling.
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_rush = !sink_rush;
      stall = sink_rush ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    int pick;
    int ready_rows [$];
    logic [7:0] pair;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= KIND_BITMAP_WRITE;
    in_tdata   <= '0;
    items_sent = 0;
    rows_read  = 0;
    src_rush   = 1'b0;
    sink_rush  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: palette extremes, bit 15 of a palette word is dropped, writes to
    // palette indexes above 15 leave the palette alone.
    send_item(KIND_PALETTE_WRITE, 9'd0,   16'h0000, 5'd31);
    send_item(KIND_PALETTE_WRITE, 9'd15,  16'hFFFF, 5'd0);
    send_item(KIND_PALETTE_WRITE, 9'd1,   16'h83E0, 5'd21);
    send_item(KIND_PALETTE_WRITE, 9'd16,  16'h5555, 5'd10);
    send_item(KIND_PALETTE_WRITE, 9'd511, 16'h2AAA, 5'd31);
    // The bottom row, which ends at the last byte address; upper value bits are dropped.
    for (int c = 0; c < TILES_ACROSS * 4; c++) begin
      case (c % 4)
        0:       pair = 8'h0F;
        1:       pair = 8'hF1;
        2:       pair = 8'h10;
        default: pair = (c < 8) ? 8'hFF : 8'h00;
      endcase
      send_item(KIND_BITMAP_WRITE, row_byte_addr(ICON_HEIGHT - 1, c),
                {(c[0] ? 8'hFF : 8'h00), pair}, 5'(c));
    end
    // The unused kind must give nothing.
    send_item(KIND_UNUSED, 9'h1FF, 16'hFFFF, 5'd31);
    send_item(KIND_ROW_READ, 9'h1FF, 16'hFFFF, 5'(ICON_HEIGHT - 1));

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        ready_rows.delete();
        for (int r = 0; r < ICON_HEIGHT; r++)
          if (row_ready(r)) ready_rows.push_back(r);
        if (ready_rows.size() == 0)
          fill_row(5'($urandom_range(0, ICON_HEIGHT - 1)));
        else
          send_item(KIND_ROW_READ, 9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)),
                    5'(ready_rows[$urandom_range(0, ready_rows.size() - 1)]));
      end else if (pick < 65) begin
        fill_row(5'($urandom_range(0, ICON_HEIGHT - 1)));
      end else if (pick < 85) begin
        send_item(KIND_BITMAP_WRITE, 9'($urandom_range(0, 511)),
                  16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)));
      end else if (pick < 95) begin
        send_item(KIND_PALETTE_WRITE,
                  ($urandom_range(0, 6) == 0) ? 9'($urandom_range(16, 511))
                                              : 9'($urandom_range(0, 15)),
                  rand_color(), 5'($urandom_range(0, 31)));
      end else begin
        send_item(KIND_UNUSED, 9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)),
                  5'($urandom_range(0, 31)));
      end
    end
    in_tvalid <= 1'b0;

    @(negedge clk);
    while (pixels_pending != 0) @(negedge clk);
    // Give a stray pixel the chance to show up before the verdict.
    repeat (40) @(negedge clk);

    $display("Sent %0d effective items, %0d of them raster row reads.", items_sent, rows_read);
    $display("Checked %0d pixels against the predicted colors.", pixels_checked);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d pixels still expected.", pixels_pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tirp_pkg.sv
rtl/core/tirp_ram.sv
rtl/core/tirp_addr_gen.sv
rtl/core/tiled_icon_raster_palette_reader.sv
sim/tirp_checker.sv
sim/tb_tiled_icon_raster_palette_reader.sv
